// ===== rtl/lfu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU way replacement package
// Sizes, event codes and the structs that run between the core and its cells.
// ----------------------------------------------------------------------------
package lfu_pkg;

   localparam int SET_WAYS   = 8;
   localparam int COUNT_BITS = 16;
   localparam int SEQ_BITS   = 32;

   localparam int OP_BITS    = 2;
   localparam int WAY_BITS   = 3;
   localparam int TCNT_BITS  = 4;

   localparam int IDX_BITS   = (SET_WAYS > 1) ? $clog2(SET_WAYS) : 1;
   localparam int CNT_BITS   = $clog2(SET_WAYS + 1);

   typedef enum logic [OP_BITS-1:0] {
      OP_INSERT = 2'd0,
      OP_ACCESS = 2'd1,
      OP_REMOVE = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   // event broadcast to every cell on a request transfer
   typedef struct packed {
      logic                valid;
      op_type              op;
      logic [WAY_BITS-1:0] way;
      logic                in_set;
      logic [SEQ_BITS-1:0] seq;
   } upd_type;

   // running best candidate handed down the chain
   typedef struct packed {
      logic                  found;
      logic [IDX_BITS-1:0]   idx;
      logic [COUNT_BITS-1:0] count;
      logic [SEQ_BITS-1:0]   order;
      logic [CNT_BITS-1:0]   ntracked;
   } cand_type;

   localparam cand_type CAND_EMPTY = '0;

endpackage

// ===== rtl/lfu_way_replacement_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU way replacement core
// Least-frequently-used victim selection for one cache set, ties to the
// oldest insertion, then to the lowest way.
//
//   channel | ports                                   | dir
//   req     | req_valid req_ready req_op req_way      | in
//   rsp     | rsp_valid rsp_ready rsp_victim_way      | out
//           | rsp_none_tracked rsp_tracked_count      |
//
// A request transfer updates all way cells; the best candidate then walks
// the chain of SET_WAYS cells, one cell per cycle, and the result is loaded
// into the response register; no new request is taken during the search.
// The next request is taken while a response still waits.
// A stalled response holds the core after the search until it is taken.
// Reset clears every way and the sequence counter.
// ----------------------------------------------------------------------------
module lfu_way_replacement_core
   import lfu_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [OP_BITS-1:0]   req_op,
   input  logic [WAY_BITS-1:0]  req_way,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [WAY_BITS-1:0]  rsp_victim_way,
   output logic                 rsp_none_tracked,
   output logic [TCNT_BITS-1:0] rsp_tracked_count
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DONE
   } state_type;

   state_type             state_ff;
   logic [IDX_BITS-1:0]   step_ff;
   logic [SEQ_BITS-1:0]   seq_ff, seq_in;
   logic                  rsp_valid_ff;
   logic [WAY_BITS-1:0]   victim_ff;
   logic                  none_ff;
   logic [TCNT_BITS-1:0]  tcnt_ff;

   logic                  req_xfer;
   logic                  in_set;
   logic                  way_tracked;
   op_type                op;
   upd_type               upd;
   logic [SET_WAYS-1:0]   tracked;
   cand_type              cand [SET_WAYS+1];
   cand_type              best;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign op        = op_type'(req_op);
   assign in_set    = (32'(req_way) < SET_WAYS);

   always_comb begin
      way_tracked = 1'b0;
      for (int i = 0; i < SET_WAYS; i++) begin
         if (32'(i) == 32'(req_way)) way_tracked = tracked[i];
      end
   end

   always_comb begin
      seq_in = seq_ff;
      if (req_xfer) begin
         if (op == OP_CLEAR) begin
            seq_in = '0;
         end else if (in_set && ((op == OP_INSERT) || ((op == OP_ACCESS) && !way_tracked))) begin
            if (seq_ff != '1) seq_in = seq_ff + SEQ_BITS'(1);
         end
      end
   end

   assign upd.valid  = req_xfer;
   assign upd.op     = op;
   assign upd.way    = req_way;
   assign upd.in_set = in_set;
   assign upd.seq    = seq_ff;

   assign cand[0] = CAND_EMPTY;

   for (genvar g = 0; g < SET_WAYS; g++) begin : g_cell
      lfu_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cell_idx    (IDX_BITS'(g)),
         .upd         (upd),
         .cand_in     (cand[g]),
         .cand_out    (cand[g+1]),
         .tracked_out (tracked[g])
      );
   end

   assign best = cand[SET_WAYS];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         seq_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seq_ff <= seq_in;
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_DONE)) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_xfer) begin
                  state_ff <= ST_SEARCH;
                  step_ff  <= '0;
               end
            end
            ST_SEARCH: begin
               if (32'(step_ff) == SET_WAYS - 1) begin
                  state_ff <= ST_DONE;
               end else begin
                  step_ff <= step_ff + IDX_BITS'(1);
               end
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  victim_ff    <= best.found ? WAY_BITS'(best.idx) : '0;
                  none_ff      <= !best.found;
                  tcnt_ff      <= TCNT_BITS'(best.ntracked);
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_victim_way    = victim_ff;
   assign rsp_none_tracked  = none_ff;
   assign rsp_tracked_count = tcnt_ff;

   a_xfer_starts_search: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff == ST_SEARCH))
      else $error("request transfer did not start a search");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside of search completion");

   a_none_consistent: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_none_tracked) |->
         ((rsp_victim_way == '0) && (rsp_tracked_count == '0)))
      else $error("empty set response carries a victim or count");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (32'(rsp_tracked_count) <= SET_WAYS))
      else $error("tracked count exceeds way count");

endmodule

// ===== rtl/lfu_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU way cell
// Holds one way's tracked bit, use count and insertion order, and passes the
// better of its own entry and the incoming candidate to the next cell.
// ----------------------------------------------------------------------------
module lfu_cell
   import lfu_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic [IDX_BITS-1:0] cell_idx,
   input  upd_type             upd,
   input  cand_type            cand_in,
   output cand_type            cand_out,
   output logic                tracked_out
);

   logic                  tracked_ff, tracked_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [SEQ_BITS-1:0]   order_ff, order_in;
   cand_type              fwd_ff, fwd_in;
   logic                  hit;
   logic                  better;

   assign hit = upd.in_set && (32'(cell_idx) == 32'(upd.way));

   always_comb begin
      tracked_in = tracked_ff;
      count_in   = count_ff;
      order_in   = order_ff;
      if (upd.valid) begin
         if (upd.op == OP_CLEAR) begin
            tracked_in = 1'b0;
            count_in   = '0;
            order_in   = '0;
         end else if (hit) begin
            unique case (upd.op)
               OP_INSERT: begin
                  tracked_in = 1'b1;
                  count_in   = COUNT_BITS'(1);
                  order_in   = upd.seq;
               end
               OP_ACCESS: begin
                  if (tracked_ff) begin
                     if (count_ff != '1) count_in = count_ff + COUNT_BITS'(1);
                  end else begin
                     tracked_in = 1'b1;
                     count_in   = COUNT_BITS'(1);
                     order_in   = upd.seq;
                  end
               end
               OP_REMOVE: begin
                  tracked_in = 1'b0;
                  count_in   = '0;
                  order_in   = '0;
               end
               default: ;
            endcase
         end
      end
   end

   // strict compare keeps the lower way on a full tie
   assign better = tracked_ff &&
                   (!cand_in.found || (count_ff < cand_in.count) ||
                    ((count_ff == cand_in.count) && (order_ff < cand_in.order)));

   always_comb begin
      fwd_in = cand_in;
      if (better) begin
         fwd_in.found = 1'b1;
         fwd_in.idx   = cell_idx;
         fwd_in.count = count_ff;
         fwd_in.order = order_ff;
      end
      fwd_in.ntracked = cand_in.ntracked + CNT_BITS'(tracked_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tracked_ff <= 1'b0;
         count_ff   <= '0;
         order_ff   <= '0;
      end else begin
         tracked_ff <= tracked_in;
         count_ff   <= count_in;
         order_ff   <= order_in;
      end
   end

   always_ff @(posedge clock) begin
      fwd_ff <= fwd_in;
   end

   assign cand_out    = fwd_ff;
   assign tracked_out = tracked_ff;

endmodule
